// ----- rtl/esmt_pkg.sv -----
`timescale 1ns / 1ps
// Package for the elevation-dependent C/N0 mask test.
// Holds the register indexes, table geometry and pipeline stage type; no dependencies.
package esmt_pkg;

    localparam int NUM_FREQ = 3;
    localparam int NUM_ENTRY = 9;
    localparam int ENTRY_W = 6;
    localparam int MASK_W = NUM_ENTRY * ENTRY_W;
    localparam int SNR_W = 14;
    localparam int THR_W = 13;

    typedef enum logic [1:0] {
        REG_MASK_ENABLE = 2'd0,
        REG_MASK_FREQ0  = 2'd1,
        REG_MASK_FREQ1  = 2'd2,
        REG_MASK_FREQ2  = 2'd3
    } reg_index_t;

    // Operands of the interpolation, registered between the two stages.
    typedef struct packed {
        logic                 test;
        logic [ENTRY_W-1:0]   lo;
        logic [ENTRY_W-1:0]   hi;
        logic [6:0]           frac;
        logic [SNR_W-1:0]     snr;
    } interp_t;

endpackage

// ----- rtl/elevation_snr_mask_test.sv -----
`timescale 1ns / 1ps
// An item taken by start passes the input, mid and result registers before its result strobe (done) rises.
// Throughput: one item per cycle; busy is always low and start is taken at every edge.
// The limit is the per-stage logic: bracket search and entry select, then two small multiplies.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (rst_n, asynchronous, active low) clears the valid pipeline and all mask registers.
// Elevation-dependent C/N0 mask test: top level, three register stages.
// Depends on esmt_pkg.
module elevation_snr_mask_test
    import esmt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    is_base,
    input  logic [2:0]              freq_index,
    input  logic signed [10:0]      elevation,
    input  logic [SNR_W-1:0]        snr,
    output logic                    done,
    output logic                    masked,
    output logic [THR_W-1:0]        threshold,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [MASK_W-1:0]       cfg_data
);

    logic [1:0]          mask_enable_reg;
    logic [MASK_W-1:0]   mask_freq_reg [NUM_FREQ];

    logic                in_valid_reg;
    logic                in_base_reg;
    logic [2:0]          in_freq_reg;
    logic signed [10:0]  in_elev_reg;
    logic [SNR_W-1:0]    in_snr_reg;

    logic                mid_valid_reg;
    interp_t             mid_reg;
    interp_t             mid_next;

    logic                done_reg;
    logic                masked_reg;
    logic [THR_W-1:0]    threshold_reg;
    logic                masked_next;
    logic [THR_W-1:0]    threshold_next;

    logic                accept;
    logic                freq_ok;
    logic [1:0]          freq_sel;
    logic [MASK_W-1:0]   packed_sel;
    logic signed [11:0]  s_val;
    logic [9:0]          s_low;
    logic [3:0]          idx;
    logic [9:0]          diff;
    logic [3:0]          lo_k;
    logic [3:0]          hi_k;
    logic [6:0]          frac;
    logic [THR_W:0]      thr_sum;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_enable_reg <= '0;
            for (int k = 0; k < NUM_FREQ; k++)
            begin
                mask_freq_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MASK_ENABLE: mask_enable_reg  <= cfg_data[1:0];
                REG_MASK_FREQ0:  mask_freq_reg[0] <= cfg_data;
                REG_MASK_FREQ1:  mask_freq_reg[1] <= cfg_data;
                REG_MASK_FREQ2:  mask_freq_reg[2] <= cfg_data;
                default:         mask_enable_reg  <= mask_enable_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_base_reg <= is_base;
            in_freq_reg <= freq_index;
            in_elev_reg <= elevation;
            in_snr_reg  <= snr;
        end
    end

    // Stage one: find the bracketing entries and the fraction between them.
    always_comb
    begin
        freq_ok    = (in_freq_reg < 3'(NUM_FREQ));
        freq_sel   = freq_ok ? in_freq_reg[1:0] : 2'd0;
        packed_sel = mask_freq_reg[freq_sel];

        s_val = 12'(in_elev_reg) + 12'sd50;
        s_low = s_val[9:0];

        idx = 4'd0;
        for (int k = 1; k <= 8; k++)
        begin
            if (s_low >= 10'(100 * k))
            begin
                idx = idx + 4'd1;
            end
        end
        diff = s_low - (10'(idx) * 10'd100);

        // Below the first knot or at or past the last one the entry is used flat.
        if (s_val < 12'sd100)
        begin
            lo_k = 4'd0;
            hi_k = 4'd0;
            frac = 7'd0;
        end
        else if (s_val >= 12'sd900)
        begin
            lo_k = 4'd8;
            hi_k = 4'd8;
            frac = 7'd0;
        end
        else
        begin
            lo_k = idx - 4'd1;
            hi_k = idx;
            frac = diff[6:0];
        end

        mid_next.test = mask_enable_reg[in_base_reg] && freq_ok;
        mid_next.lo   = packed_sel[ENTRY_W * lo_k +: ENTRY_W];
        mid_next.hi   = packed_sel[ENTRY_W * hi_k +: ENTRY_W];
        mid_next.frac = frac;
        mid_next.snr  = in_snr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            mid_reg <= mid_next;
        end
    end

    // Stage two: weighted sum of the two entries and the compare.
    always_comb
    begin
        thr_sum = (14'(7'd100 - mid_reg.frac) * 14'(mid_reg.lo))
                + (14'(mid_reg.frac) * 14'(mid_reg.hi));
        if (mid_reg.test)
        begin
            threshold_next = thr_sum[THR_W-1:0];
            masked_next    = (mid_reg.snr < SNR_W'(thr_sum[THR_W-1:0]));
        end
        else
        begin
            threshold_next = '0;
            masked_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_valid_reg)
        begin
            masked_reg    <= masked_next;
            threshold_reg <= threshold_next;
        end
    end

    assign done      = done_reg;
    assign masked    = masked_reg;
    assign threshold = threshold_reg;

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##2 done)
        else $error("item accepted without a result three cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result strobe without an accepted item");

    a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (threshold <= THR_W'(6300)))
        else $error("threshold above the largest table value");

    a_masked_thr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && masked) |-> (threshold != '0))
        else $error("masked flagged with a zero threshold");
`endif

endmodule

// ----- sim/elevation_snr_mask_test_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the elevation-dependent C/N0 mask test.
// Holds a scoreboard class that predicts masked and threshold per item, plus the drivers.
// Depends on esmt_pkg and elevation_snr_mask_test.
module elevation_snr_mask_test_test;
    import esmt_pkg::*;

    class mask_scoreboard;
        typedef struct {
            logic             masked;
            logic [THR_W-1:0] threshold;
        } verdict_t;

        logic [1:0]        enable_bits;
        logic [MASK_W-1:0] freq_table [NUM_FREQ];
        verdict_t          pending_verdicts [$];
        int                mismatches;

        function new();
            enable_bits = '0;
            foreach (freq_table[k])
                freq_table[k] = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [MASK_W-1:0] data);
            case (reg_index_t'(index))
                REG_MASK_ENABLE: enable_bits = data[1:0];
                REG_MASK_FREQ0:  freq_table[0] = data;
                REG_MASK_FREQ1:  freq_table[1] = data;
                REG_MASK_FREQ2:  freq_table[2] = data;
                default: ;
            endcase
        endfunction

        // Linear interpolation between the thresholds at 5, 15, ..., 85 degrees,
        // in 0.01 dBHz; the offset of 50 puts the first breakpoint at s = 100.
        function int interp_threshold(int fi, int el);
            logic [MASK_W-1:0] row;
            int s;
            int seg;
            int frac;
            row = freq_table[fi];
            s = el + 50;
            if (s < 100)
                return 100 * int'(row[ENTRY_W-1:0]);
            if (s >= 900)
                return 100 * int'(row[8*ENTRY_W +: ENTRY_W]);
            seg = s / 100;
            frac = s - 100 * seg;
            return (100 - frac) * int'(row[(seg-1)*ENTRY_W +: ENTRY_W])
                + frac * int'(row[seg*ENTRY_W +: ENTRY_W]);
        endfunction

        function void note_item(logic base, logic [2:0] fi, logic signed [10:0] el,
                                logic [SNR_W-1:0] level);
            verdict_t v;
            int thr;
            v.masked = 1'b0;
            v.threshold = '0;
            if (enable_bits[base] && int'(fi) < NUM_FREQ)
            begin
                thr = interp_threshold(int'(fi), int'(el));
                v.masked = (int'(level) < thr);
                v.threshold = thr[THR_W-1:0];
            end
            pending_verdicts.push_back(v);
        endfunction

        function void check_result(logic masked, logic [THR_W-1:0] threshold);
            verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: masked %0d threshold %0d", masked, threshold);
                return;
            end
            v = pending_verdicts.pop_front();
            if (masked !== v.masked || threshold !== v.threshold)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected masked %0d threshold %0d, got masked %0d threshold %0d",
                             v.masked, v.threshold, masked, threshold);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              is_base;
    logic [2:0]        freq_index;
    logic signed [10:0] elevation;
    logic [SNR_W-1:0]  snr;
    logic              done;
    logic              masked;
    logic [THR_W-1:0]  threshold;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [MASK_W-1:0] cfg_data;

    mask_scoreboard sb = new();

    elevation_snr_mask_test i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .is_base    (is_base),
        .freq_index (freq_index),
        .elevation  (elevation),
        .snr        (snr),
        .done       (done),
        .masked     (masked),
        .threshold  (threshold),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Results are checked before the item of the same edge is noted; a result
    // always belongs to an item taken at an earlier edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(masked, threshold);
            if (start && !busy)
                sb.note_item(is_base, freq_index, elevation, snr);
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    task automatic load_config(input logic [1:0] enable, input logic [MASK_W-1:0] t0,
                               input logic [MASK_W-1:0] t1, input logic [MASK_W-1:0] t2);
        reg_index_t idx [4];
        logic [MASK_W-1:0] val [4];
        idx = '{REG_MASK_ENABLE, REG_MASK_FREQ0, REG_MASK_FREQ1, REG_MASK_FREQ2};
        val = '{MASK_W'(enable), t0, t1, t2};
        for (int k = 0; k < 4; k++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            @(posedge clk);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input int gap, input logic base, input logic [2:0] fi,
                             input logic signed [10:0] el, input logic [SNR_W-1:0] level);
        bit taken;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        is_base <= base;
        freq_index <= fi;
        elevation <= el;
        snr <= level;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
    endtask

    // Stop issuing and wait until every outstanding item has produced its result.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic run_directed();
        logic [MASK_W-1:0] ramp;
        logic [MASK_W-1:0] alt;
        for (int k = 0; k < 9; k++)
        begin
            ramp[k*ENTRY_W +: ENTRY_W] = ENTRY_W'(7 * k + 3);
            alt[k*ENTRY_W +: ENTRY_W] = (k % 2 == 0) ? '1 : '0;
        end
        // Reset state: both receivers disabled.
        send_item(0, 1'b0, 3'd0, 11'sd0, 14'd100);
        send_item(0, 1'b1, 3'd1, 11'sd300, 14'd0);
        drain();
        load_config(2'b11, '1, ramp, alt);
        send_item(0, 1'b0, 3'd0, -11'sd1024, 14'd0);
        send_item(0, 1'b0, 3'd0, 11'sd1023, 14'h3fff);
        send_item(0, 1'b0, 3'd0, 11'sd0, 14'd6299);
        send_item(0, 1'b1, 3'd0, 11'sd0, 14'd6300);
        send_item(0, 1'b0, 3'd1, 11'sd49, 14'd500);
        send_item(0, 1'b0, 3'd1, 11'sd50, 14'd500);
        send_item(0, 1'b0, 3'd1, 11'sd51, 14'd500);
        send_item(0, 1'b1, 3'd1, 11'sd149, 14'd1000);
        send_item(0, 1'b0, 3'd1, 11'sd849, 14'd5000);
        send_item(0, 1'b0, 3'd1, 11'sd850, 14'd5000);
        send_item(0, 1'b0, 3'd1, 11'sd851, 14'd5000);
        send_item(0, 1'b0, 3'd1, -11'sd900, 14'd0);
        send_item(0, 1'b1, 3'd1, 11'sd900, 14'd6000);
        send_item(0, 1'b0, 3'd2, 11'sd55, 14'd3000);
        send_item(0, 1'b1, 3'd2, 11'sd455, 14'd3000);
        // Frequency indexes past the table count are never masked.
        for (int f = NUM_FREQ; f < 8; f++)
            send_item(0, f[0], 3'(f), 11'sd300, 14'd0);
        drain();
        load_config(2'b01, '1, ramp, alt);
        send_item(0, 1'b0, 3'd0, 11'sd300, 14'd0);
        send_item(0, 1'b1, 3'd0, 11'sd300, 14'd0);
        drain();
        load_config(2'b10, '1, ramp, alt);
        send_item(0, 1'b0, 3'd0, 11'sd300, 14'd0);
        send_item(0, 1'b1, 3'd0, 11'sd300, 14'd0);
        drain();
    endtask

    task automatic run_random(input int count, input bit allow_gaps);
        int gap;
        int lvl;
        logic base;
        logic [2:0] fi;
        logic signed [10:0] el;
        logic [SNR_W-1:0] level;
        for (int n = 0; n < count; n++)
        begin
            gap = 0;
            if (allow_gaps && $urandom_range(0, 5) == 0)
                gap = $urandom_range(1, 9);
            if ($urandom_range(0, 6) == 0)
            begin
                base = 1'($urandom);
                fi = 3'($urandom);
                el = 11'($urandom);
                level = SNR_W'($urandom);
            end
            else
            begin
                base = 1'($urandom_range(0, 1));
                fi = 3'($urandom_range(0, NUM_FREQ - 1));
                el = 11'(int'($urandom_range(0, 1100)) - 150);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        // Land on or right next to the threshold.
                        lvl = sb.interp_threshold(int'(fi), int'(el))
                            + int'($urandom_range(0, 4)) - 2;
                        level = (lvl < 0) ? '0 : SNR_W'(lvl);
                    end
                    1: level = SNR_W'($urandom_range(0, 6500));
                    default: level = SNR_W'($urandom);
                endcase
            end
            send_item(gap, base, fi, el, level);
        end
    endtask

    initial
    begin
        logic [1:0] enable;
        logic [MASK_W-1:0] tbl [3];
        rst_n = 1'b0;
        start = 1'b0;
        is_base = 1'b0;
        freq_index = '0;
        elevation = '0;
        snr = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < 8; p++)
        begin
            enable = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b11;
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(0, 5))
                    0: tbl[k] = '0;
                    1: tbl[k] = '1;
                    default: tbl[k] = MASK_W'({$urandom, $urandom});
                endcase
            end
            load_config(enable, tbl[0], tbl[1], tbl[2]);
            run_random(165, p != 7);
            drain();
        end
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
            $display("elevation_snr_mask_test_test: clean");
        else
            $display("elevation_snr_mask_test_test: errors");
        $finish;
    end

    initial
    begin
        #300000;
        $display("elevation_snr_mask_test_test: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/esmt_pkg.sv
rtl/elevation_snr_mask_test.sv
sim/elevation_snr_mask_test_test.sv
